// ===== rtl/vop_pkg.sv =====
// Shared widths and stage payload types for the virtual obstacle position core.
// No dependencies; used by rtl/virtual_obstacle_position_core.sv.
package vop_pkg;

   localparam int CoordW  = 32;              // Q16.16 coordinate
   localparam int DiffW   = CoordW + 1;      // exact difference of two coordinates
   localparam int GainW   = 16;              // unsigned Q8.8 gain
   localparam int GainFrac = 8;
   localparam int ProdW   = GainW + DiffW;   // gain times magnitude
   localparam int ShiftW  = ProdW - GainFrac; // shift magnitude, unsigned Q25.16
   localparam int HalfLoW = 21;              // low split of a shift-wide operand
   localparam int HalfHiW = ShiftW - HalfLoW;
   localparam int SqW     = 2 * ShiftW;      // one exact square
   localparam int RootW   = 42;              // bits of an integer square root
   localparam int RadW    = 2 * RootW;       // radicand width (sum of two squares)
   localparam int RemW    = RootW + 2;       // square-root partial remainder
   localparam int FracW   = 32;              // fraction bits of d/m
   localparam int RatioW  = FracW + 1;       // d/m in Q1.32, at most 1.0
   localparam int RatLoW  = 17;              // low split of the ratio
   localparam int RatHiW  = RatioW - RatLoW;
   localparam int ScaleW  = ShiftW + RatioW; // shift times ratio
   localparam int SumW    = ShiftW + 2;      // signed coordinate plus shift

   // Per-item data that rides along the pipe from stage C to the output
   typedef struct packed {
      logic signed [CoordW-1:0] ox;
      logic signed [CoordW-1:0] oy;
      logic                     negx;
      logic                     negy;
      logic [ShiftW-1:0]        sx;
      logic [ShiftW-1:0]        sy;
   } side_type;

   // Partial products of one square
   typedef struct packed {
      logic [2*HalfHiW-1:0]         hh;
      logic [HalfHiW+HalfLoW-1:0]   hl;
      logic [2*HalfLoW-1:0]         ll;
   } sqpp_type;

   // One digit-recurrence square root in flight
   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [RootW-1:0] root;
      logic [RadW-1:0]  rad;
   } root_type;

   // One restoring division in flight
   typedef struct packed {
      logic [RootW-1:0]  rem;
      logic [RootW-1:0]  den;
      logic [RatioW-1:0] quo;
   } div_type;

   // Partial products of shift times ratio
   typedef struct packed {
      logic [HalfHiW+RatHiW-1:0] p11;
      logic [HalfHiW+RatLoW-1:0] p10;
      logic [HalfLoW+RatHiW-1:0] p01;
      logic [HalfLoW+RatLoW-1:0] p00;
   } scpp_type;

endpackage

// ===== rtl/virtual_obstacle_position_core.sv =====
// Virtual obstacle position core: pipelined shift, squares, roots, ratio, scaling.
// Depends on rtl/vop_pkg.sv for widths and stage types.
// Throughput: one item per cycle; set by the 42-stage square-root and 33-stage
// divide pipes, each stage one add/compare. The pipe stalls as a whole while a
// rsp beat waits. Reset (synchronous) empties the pipe and sets the gain to 1.0.
module virtual_obstacle_position_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // obstacle_x, obstacle_y, obstacle_vel_x, obstacle_vel_y,
   // robot_x, robot_y, robot_vel_x, robot_vel_y (32 bits each, lowest first)
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // virtual_x [31:0], virtual_y [63:32]
   output logic [63:0]  rsp_tdata,
   // was_scaled [0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   localparam int CW = vop_pkg::CoordW;
   localparam int DW = vop_pkg::DiffW;
   localparam int SW = vop_pkg::ShiftW;
   localparam int LW = vop_pkg::HalfLoW;
   localparam int NRoot = vop_pkg::RootW;
   localparam int NDiv = vop_pkg::FracW;
   localparam logic signed [vop_pkg::SumW-1:0] SatMax = vop_pkg::SumW'((64'sd1 <<< (CW-1)) - 1);
   localparam logic signed [vop_pkg::SumW-1:0] SatMin = vop_pkg::SumW'(-(64'sd1 <<< (CW-1)));

   // ---------------- helpers ----------------
   function automatic vop_pkg::sqpp_type sq_split(logic [SW-1:0] a);
      vop_pkg::sqpp_type p;
      p.hh = a[SW-1:LW] * a[SW-1:LW];
      p.hl = a[SW-1:LW] * a[LW-1:0];
      p.ll = a[LW-1:0] * a[LW-1:0];
      return p;
   endfunction

   function automatic logic [vop_pkg::SqW-1:0] sq_join(vop_pkg::sqpp_type p);
      return (vop_pkg::SqW'(p.hh) << (2*LW)) + (vop_pkg::SqW'(p.hl) << (LW+1))
           + vop_pkg::SqW'(p.ll);
   endfunction

   function automatic vop_pkg::root_type root_step(vop_pkg::root_type cur);
      logic [vop_pkg::RemW+1:0] acc;
      logic [vop_pkg::RemW+1:0] trial;
      vop_pkg::root_type nxt;
      acc   = {cur.rem, cur.rad[vop_pkg::RadW-1 -: 2]};
      trial = {2'b00, cur.root, 2'b01};
      nxt.rad = {cur.rad[vop_pkg::RadW-3:0], 2'b00};
      if (acc >= trial) begin
         nxt.rem  = vop_pkg::RemW'(acc - trial);
         nxt.root = {cur.root[NRoot-2:0], 1'b1};
      end else begin
         nxt.rem  = acc[vop_pkg::RemW-1:0];
         nxt.root = {cur.root[NRoot-2:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic vop_pkg::div_type div_step(vop_pkg::div_type cur);
      logic [NRoot:0] t;
      vop_pkg::div_type nxt;
      t = {cur.rem, 1'b0};
      nxt.den = cur.den;
      if (t >= {1'b0, cur.den}) begin
         nxt.rem = NRoot'(t - {1'b0, cur.den});
         nxt.quo = {cur.quo[vop_pkg::RatioW-2:0], 1'b1};
      end else begin
         nxt.rem = t[NRoot-1:0];
         nxt.quo = {cur.quo[vop_pkg::RatioW-2:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic vop_pkg::scpp_type sc_split(logic [SW-1:0] a,
                                                 logic [vop_pkg::RatioW-1:0] r);
      vop_pkg::scpp_type p;
      p.p11 = a[SW-1:LW] * r[vop_pkg::RatioW-1:vop_pkg::RatLoW];
      p.p10 = a[SW-1:LW] * r[vop_pkg::RatLoW-1:0];
      p.p01 = a[LW-1:0] * r[vop_pkg::RatioW-1:vop_pkg::RatLoW];
      p.p00 = a[LW-1:0] * r[vop_pkg::RatLoW-1:0];
      return p;
   endfunction

   function automatic logic [SW-1:0] sc_join(vop_pkg::scpp_type p);
      logic [vop_pkg::ScaleW-1:0] s;
      s = (vop_pkg::ScaleW'(p.p11) << (LW + vop_pkg::RatLoW))
        + (vop_pkg::ScaleW'(p.p10) << LW)
        + (vop_pkg::ScaleW'(p.p01) << vop_pkg::RatLoW)
        + vop_pkg::ScaleW'(p.p00);
      return s[NDiv +: SW];
   endfunction

   function automatic logic [CW-1:0] place(logic signed [CW-1:0] o, logic neg,
                                           logic [SW-1:0] t);
      logic signed [vop_pkg::SumW-1:0] v;
      logic signed [vop_pkg::SumW-1:0] te;
      te = $signed({1'b0, t});
      v  = neg ? (vop_pkg::SumW'(o) - te) : (vop_pkg::SumW'(o) + te);
      if (v > SatMax) v = SatMax;
      if (v < SatMin) v = SatMin;
      return v[CW-1:0];
   endfunction

   // ---------------- control ----------------
   logic adv;
   logic rsp_tvalid_ff;
   logic [vop_pkg::GainW-1:0] gain_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;

   // gain register
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= vop_pkg::GainW'(256);
      end else if (csr_valid) begin
         gain_ff <= csr_data;
      end
   end

   // ---------------- stage A: differences ----------------
   logic a_vld_ff;
   logic signed [DW-1:0] a_dvx_ff, a_dvy_ff, a_dpx_ff, a_dpy_ff;
   logic signed [CW-1:0] a_ox_ff, a_oy_ff;

   // ---------------- stage B: magnitudes ----------------
   logic b_vld_ff;
   logic [DW-1:0] b_mvx_ff, b_mvy_ff, b_px_ff, b_py_ff;
   logic b_nx_ff, b_ny_ff;
   logic signed [CW-1:0] b_ox_ff, b_oy_ff;

   // ---------------- stage C: shift vector ----------------
   logic c_vld_ff;
   vop_pkg::side_type c_side_ff;
   logic [DW-1:0] c_px_ff, c_py_ff;
   logic [vop_pkg::ProdW-1:0] c_prx_in, c_pry_in;

   // ---------------- stage D: square partials ----------------
   logic d_vld_ff;
   vop_pkg::side_type d_side_ff;
   vop_pkg::sqpp_type d_ppx_ff, d_ppy_ff, d_spx_ff, d_spy_ff;

   // ---------------- stage E: squares ----------------
   logic e_vld_ff;
   vop_pkg::side_type e_side_ff;
   logic [vop_pkg::SqW-1:0] e_dx_ff, e_dy_ff, e_sx_ff, e_sy_ff;

   // ---------------- stage F: sums of squares ----------------
   logic f_vld_ff;
   vop_pkg::side_type f_side_ff;
   logic [vop_pkg::RadW-1:0] f_d2_ff, f_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_tvalid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
      end
   end

   assign c_prx_in = b_mvx_ff * gain_ff;
   assign c_pry_in = b_mvy_ff * gain_ff;

   // advance the front stages
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ox_ff  <= $signed(req_tdata[0 +: CW]);
         a_oy_ff  <= $signed(req_tdata[CW +: CW]);
         a_dvx_ff <= DW'($signed(req_tdata[2*CW +: CW])) - DW'($signed(req_tdata[6*CW +: CW]));
         a_dvy_ff <= DW'($signed(req_tdata[3*CW +: CW])) - DW'($signed(req_tdata[7*CW +: CW]));
         a_dpx_ff <= DW'($signed(req_tdata[4*CW +: CW])) - DW'($signed(req_tdata[0 +: CW]));
         a_dpy_ff <= DW'($signed(req_tdata[5*CW +: CW])) - DW'($signed(req_tdata[CW +: CW]));

         b_nx_ff  <= a_dvx_ff[DW-1];
         b_ny_ff  <= a_dvy_ff[DW-1];
         b_mvx_ff <= a_dvx_ff[DW-1] ? DW'(-a_dvx_ff) : DW'(a_dvx_ff);
         b_mvy_ff <= a_dvy_ff[DW-1] ? DW'(-a_dvy_ff) : DW'(a_dvy_ff);
         b_px_ff  <= a_dpx_ff[DW-1] ? DW'(-a_dpx_ff) : DW'(a_dpx_ff);
         b_py_ff  <= a_dpy_ff[DW-1] ? DW'(-a_dpy_ff) : DW'(a_dpy_ff);
         b_ox_ff  <= a_ox_ff;
         b_oy_ff  <= a_oy_ff;

         c_side_ff.ox   <= b_ox_ff;
         c_side_ff.oy   <= b_oy_ff;
         c_side_ff.negx <= b_nx_ff;
         c_side_ff.negy <= b_ny_ff;
         c_side_ff.sx   <= c_prx_in[vop_pkg::ProdW-1:vop_pkg::GainFrac];
         c_side_ff.sy   <= c_pry_in[vop_pkg::ProdW-1:vop_pkg::GainFrac];
         c_px_ff        <= b_px_ff;
         c_py_ff        <= b_py_ff;

         d_side_ff <= c_side_ff;
         d_ppx_ff  <= sq_split(SW'(c_px_ff));
         d_ppy_ff  <= sq_split(SW'(c_py_ff));
         d_spx_ff  <= sq_split(c_side_ff.sx);
         d_spy_ff  <= sq_split(c_side_ff.sy);

         e_side_ff <= d_side_ff;
         e_dx_ff   <= sq_join(d_ppx_ff);
         e_dy_ff   <= sq_join(d_ppy_ff);
         e_sx_ff   <= sq_join(d_spx_ff);
         e_sy_ff   <= sq_join(d_spy_ff);

         f_side_ff <= e_side_ff;
         f_d2_ff   <= vop_pkg::RadW'(e_dx_ff) + vop_pkg::RadW'(e_dy_ff);
         f_s2_ff   <= vop_pkg::RadW'(e_sx_ff) + vop_pkg::RadW'(e_sy_ff);
      end
   end

   // ---------------- square-root pipe (both roots side by side) ----------------
   logic              rt_vld_ff  [0:NRoot];
   logic              rt_scl_ff  [0:NRoot];
   vop_pkg::side_type rt_side_ff [0:NRoot];
   vop_pkg::root_type rt_d_ff    [0:NRoot];
   vop_pkg::root_type rt_m_ff    [0:NRoot];
   vop_pkg::root_type rt_d_in    [1:NRoot];
   vop_pkg::root_type rt_m_in    [1:NRoot];

   // load: compare and seed the roots
   always_ff @(posedge clock) begin
      if (reset) begin
         rt_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         rt_vld_ff[0] <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_scl_ff[0]  <= f_d2_ff < f_s2_ff;
         rt_side_ff[0] <= f_side_ff;
         rt_d_ff[0]    <= '{rem: '0, root: '0, rad: f_d2_ff};
         rt_m_ff[0]    <= '{rem: '0, root: '0, rad: f_s2_ff};
      end
   end

   for (genvar i = 0; i < NRoot; i++) begin : g_root
      assign rt_d_in[i+1] = root_step(rt_d_ff[i]);
      assign rt_m_in[i+1] = root_step(rt_m_ff[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            rt_vld_ff[i+1] <= rt_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_scl_ff[i+1]  <= rt_scl_ff[i];
            rt_side_ff[i+1] <= rt_side_ff[i];
            rt_d_ff[i+1]    <= rt_d_in[i+1];
            rt_m_ff[i+1]    <= rt_m_in[i+1];
         end
      end
   end

   // ---------------- divide pipe: d * 2^32 / m ----------------
   logic              dv_vld_ff  [0:NDiv];
   logic              dv_scl_ff  [0:NDiv];
   vop_pkg::side_type dv_side_ff [0:NDiv];
   vop_pkg::div_type  dv_ff      [0:NDiv];
   vop_pkg::div_type  dv_in      [0:NDiv];
   logic [NRoot-1:0]  dv_num;
   logic [NRoot-1:0]  dv_den;
   logic              dv_first;

   // integer digit of the quotient
   assign dv_num   = rt_d_ff[NRoot].root;
   assign dv_den   = rt_m_ff[NRoot].root;
   assign dv_first = dv_num >= dv_den;
   assign dv_in[0] = '{rem: dv_first ? NRoot'(dv_num - dv_den) : dv_num,
                       den: dv_den,
                       quo: vop_pkg::RatioW'(dv_first)};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= rt_vld_ff[NRoot];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_scl_ff[0]  <= rt_scl_ff[NRoot];
         dv_side_ff[0] <= rt_side_ff[NRoot];
         dv_ff[0]      <= dv_in[0];
      end
   end

   for (genvar i = 0; i < NDiv; i++) begin : g_div
      assign dv_in[i+1] = div_step(dv_ff[i]);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[i+1] <= dv_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_scl_ff[i+1]  <= dv_scl_ff[i];
            dv_side_ff[i+1] <= dv_side_ff[i];
            dv_ff[i+1]      <= dv_in[i+1];
         end
      end
   end

   // ---------------- scaling and final placement ----------------
   logic              sp_vld_ff, sp_scl_ff;
   vop_pkg::side_type sp_side_ff;
   vop_pkg::scpp_type sp_x_ff, sp_y_ff;

   logic              st_vld_ff, st_scl_ff;
   vop_pkg::side_type st_side_ff;
   logic [SW-1:0]     st_tx_ff, st_ty_ff;

   logic [63:0]       rsp_tdata_ff;
   logic              rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_vld_ff     <= 1'b0;
         st_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         sp_vld_ff     <= dv_vld_ff[NDiv];
         st_vld_ff     <= sp_vld_ff;
         rsp_tvalid_ff <= st_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_scl_ff  <= dv_scl_ff[NDiv];
         sp_side_ff <= dv_side_ff[NDiv];
         sp_x_ff    <= sc_split(dv_side_ff[NDiv].sx, dv_ff[NDiv].quo);
         sp_y_ff    <= sc_split(dv_side_ff[NDiv].sy, dv_ff[NDiv].quo);

         // keep the raw shift when no scaling applies
         st_scl_ff  <= sp_scl_ff;
         st_side_ff <= sp_side_ff;
         st_tx_ff   <= sp_scl_ff ? sc_join(sp_x_ff) : sp_side_ff.sx;
         st_ty_ff   <= sp_scl_ff ? sc_join(sp_y_ff) : sp_side_ff.sy;

         rsp_tdata_ff <= {place(st_side_ff.oy, st_side_ff.negy, st_ty_ff),
                          place(st_side_ff.ox, st_side_ff.negx, st_tx_ff)};
         rsp_tuser_ff <= st_scl_ff;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

// ===== sim/tb_virtual_obstacle_position_core.sv =====
// Self-checking bench for virtual_obstacle_position_core: directed table plus random
// obstacle/robot pairs, gain changes between phases, random idling on both streams.
// Depends on rtl/vop_pkg.sv and rtl/virtual_obstacle_position_core.sv.
module tb_virtual_obstacle_position_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PipeLat  = 85;
   localparam int CycleCap = 400000;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic               scaled;
   } place_type;

   typedef struct {
      logic [255:0] data;
      logic         has_exp;
      place_type    exp;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [15:0]  csr_data = '0;

   logic [15:0]  gain_now = 16'd256;
   place_type    place_queue[$];
   int           mismatches = 0;
   int           cycles = 0;
   bit           calm = 1'b0;

   virtual_obstacle_position_core dut (.*);

   always #10 clock = ~clock;

   // Watchdog on cycle count
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleCap) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // floor(sqrt(x)) for x below 2^84
   function automatic logic [41:0] root_floor(logic [83:0] x);
      logic [41:0] r;
      logic [41:0] t;
      r = '0;
      for (int b = 41; b >= 0; b--) begin
         t = r | (42'd1 << b);
         if ({42'd0, t} * {42'd0, t} <= x) r = t;
      end
      return r;
   endfunction

   // Predict the virtual obstacle for one pair under the current gain
   function automatic place_type virtual_place(logic [255:0] d);
      logic signed [63:0] ox, oy, dvx, dvy, dpx, dpy, vx, vy;
      logic [63:0] sx, sy, px, py, tx, ty, rt, dr, mr;
      logic [83:0] d2, s2;
      logic [127:0] prod;
      bit nx, ny;
      place_type p;
      ox  = $signed(d[31:0]);
      oy  = $signed(d[63:32]);
      dvx = $signed(d[95:64]) - $signed(d[223:192]);
      dvy = $signed(d[127:96]) - $signed(d[255:224]);
      dpx = $signed(d[159:128]) - ox;
      dpy = $signed(d[191:160]) - oy;
      nx = dvx < 0;
      ny = dvy < 0;
      sx = (64'(gain_now) * 64'(nx ? -dvx : dvx)) >> 8;
      sy = (64'(gain_now) * 64'(ny ? -dvy : dvy)) >> 8;
      px = dpx < 0 ? -dpx : dpx;
      py = dpy < 0 ? -dpy : dpy;
      d2 = 84'(px) * 84'(px) + 84'(py) * 84'(py);
      s2 = 84'(sx) * 84'(sx) + 84'(sy) * 84'(sy);
      p.scaled = d2 < s2;
      tx = sx;
      ty = sy;
      if (p.scaled) begin
         dr = 64'(root_floor(d2));
         mr = 64'(root_floor(s2));
         rt = 64'((128'(dr) << 32) / 128'(mr));
         prod = 128'(sx) * 128'(rt);
         tx = 64'(prod >> 32);
         prod = 128'(sy) * 128'(rt);
         ty = 64'(prod >> 32);
      end
      vx = ox + (nx ? -$signed(tx) : $signed(tx));
      vy = oy + (ny ? -$signed(ty) : $signed(ty));
      p.vx = vx > 64'sd2147483647 ? 32'h7fffffff :
             vx < -64'sd2147483648 ? 32'h80000000 : vx[31:0];
      p.vy = vy > 64'sd2147483647 ? 32'h7fffffff :
             vy < -64'sd2147483648 ? 32'h80000000 : vy[31:0];
      return p;
   endfunction

   function automatic logic [255:0] pack_pair(int ox, int oy, int ovx, int ovy,
                                              int rx, int ry, int rvx, int rvy);
      return {32'(rvy), 32'(rvx), 32'(ry), 32'(rx), 32'(ovy), 32'(ovx), 32'(oy), 32'(ox)};
   endfunction

   // Random value biased toward extremes and small magnitudes
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
         default: return $urandom;
      endcase
   endfunction

   // Check each rsp beat against the oldest prediction
   always @(posedge clock) begin
      place_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{vx: rsp_tdata[31:0], vy: rsp_tdata[63:32], scaled: rsp_tuser};
         if (place_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %h", got);
         end else begin
            want = place_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h s=%b got x=%h y=%h s=%b",
                           want.vx, want.vy, want.scaled, got.vx, got.vy, got.scaled);
            end
         end
      end
   end

   // Sink idles about 15% of cycles except during calm stretches
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 15);
   end

   // Idle at random, then hold the beat until it is taken
   task automatic send_pair(logic [255:0] d, bit has_exp, place_type exp);
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      place_queue.push_back(has_exp ? exp : virtual_place(d));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (place_queue.size() != 0) @(posedge clock);
      repeat (PipeLat + 10) @(posedge clock);
   endtask

   task automatic write_gain(logic [15:0] g);
      csr_valid <= 1'b1;
      csr_data  <= g;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gain_now = g;
      @(posedge clock);
   endtask

   row_type rows[$];
   logic [15:0] gains[6] = '{16'd0, 16'hffff, 16'd1, 16'd128, 16'd777, 16'd256};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed results only where obvious at gain 1.0
      rows.push_back('{pack_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0}});
      rows.push_back('{pack_pair(5 << 16, -3 << 16, 7, 7, 9, 9, 7, 7), 1,
                       '{5 << 16, -3 << 16, 0}});
      rows.push_back('{pack_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff),
                       1, '{32'h7fffffff, 32'h80000000, 1}});
      rows.push_back('{pack_pair(0, 0, 1 << 16, 0, 0, 0, 0, 0), 1, '{0, 0, 1}});
      rows.push_back('{pack_pair(0, 0, 1 << 16, 0, 1 << 16, 0, 0, 0), 1, '{1 << 16, 0, 0}});
      rows.push_back('{pack_pair(0, 0, 4 << 16, 3 << 16, 1 << 16, 0, 0, 0), 0, '{0, 0, 0}});
      rows.push_back('{pack_pair(100, -100, -5 << 16, 2 << 16, 3, 3, 0, 0), 0, '{0, 0, 0}});
      rows.push_back('{pack_pair(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000),
                       0, '{0, 0, 0}});
      rows.push_back('{pack_pair(32'hffffffff, 1, 32'h55555555, 32'haaaaaaaa,
                                 32'haaaaaaaa, 32'h55555555, 32'hffffffff, 0), 0, '{0, 0, 0}});
      rows.push_back('{pack_pair(0, 0, 3 << 16, 4 << 16, 3 << 16, 4 << 16, 0, 0),
                       0, '{0, 0, 0}});
      foreach (rows[i]) send_pair(rows[i].data, rows[i].has_exp, rows[i].exp);
      drain();

      // Random phases, one gain setting each
      foreach (gains[g]) begin
         write_gain(gains[g]);
         for (int n = 0; n < 100; n++) begin
            logic [255:0] d;
            calm = (n >= 40 && n < 60);
            for (int f = 0; f < 8; f++) d[32*f +: 32] = pick_coord();
            // near-miss pairs land close to the scaling boundary
            if (n % 3 == 0) begin
               d[159:128] = d[31:0] + $urandom_range(0, 1 << 18);
               d[191:160] = d[63:32] - $urandom_range(0, 1 << 18);
            end
            send_pair(d, 0, '{0, 0, 0});
         end
         calm = 1'b0;
         drain();
      end

      if (mismatches == 0 && place_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/vop_pkg.sv
rtl/virtual_obstacle_position_core.sv
sim/tb_virtual_obstacle_position_core.sv
